FILE: design/efe_pkg.sv
// efe_pkg: shared types, framing constants and CRC-8 / escape functions
// for the escaped frame encoder. No dependencies.
`default_nettype none

package efe_pkg;

	localparam logic [7:0] HEAD_BYTE = 8'h7F;
	localparam logic [7:0] TAIL_BYTE = 8'hF0;
	localparam logic [7:0] ESC_BYTE  = 8'hFF;
	localparam logic [7:0] ESC_HEAD  = 8'h5F;
	localparam logic [7:0] ESC_TAIL  = 8'hD0;
	localparam logic [7:0] ESC_ESC   = 8'hDF;
	localparam logic [7:0] CRC_INIT  = 8'hFF;
	localparam logic [7:0] CRC_POLY  = 8'h07;

	localparam int MAX_BYTES = 6;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int IDX_W     = $clog2(MAX_BYTES);

	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
	} esc_t;

	// expanded output words of one input word
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
		logic                      closes;
	} efe_frame_t;

	function automatic esc_t escape(input logic [7:0] b);
		esc_t e;
		e.two = 1'b1;
		e.b0  = ESC_BYTE;
		e.b1  = ESC_ESC;
		case (b)
			HEAD_BYTE: e.b1 = ESC_HEAD;
			TAIL_BYTE: e.b1 = ESC_TAIL;
			ESC_BYTE:  e.b1 = ESC_ESC;
			default: begin
				e.two = 1'b0;
				e.b0  = b;
				e.b1  = 8'h00;
			end
		endcase
		return e;
	endfunction

	// MSB-first CRC-8 over one byte; unrolls to an xor network
	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/escaped_frame_encoder_crc8.sv
// escaped_frame_encoder_crc8: top level, input register plus efe_expand
// and efe_out_buf. Uses efe_pkg.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready   | payload_byte, first_byte, last_byte
//  out     | out_valid / out_ready | out_byte, frame_end
//
// Each input word gives 1 to 6 output words, sent one per cycle from the
// result register while out_ready is high; an input word holds the output
// until all its words are sent. Its first output word passes through the
// input register and then the result register. A new input word is
// taken while the previous one drains. Reset clears the valid flags and
// sets the running CRC to 0xFF. A stalled output holds the input register.
`default_nettype none

module escaped_frame_encoder_crc8 import efe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] payload_byte,
	input  wire logic       first_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            frame_end
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       last_s1;
	logic       buf_free;
	logic       take_s1;
	efe_frame_t frame;

	assign take_s1  = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= payload_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	efe_expand u_expand (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data_s1),
		.first  (first_s1),
		.last   (last_s1),
		.take   (take_s1),
		.frame  (frame)
	);

	efe_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take_s1),
		.frame     (frame),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.frame_end (frame_end)
	);

`ifndef NO_ASSERTIONS
	a_tail_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> out_byte == TAIL_BYTE)
		else $error("frame_end on a word other than the tail");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with an empty input register");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |=> out_valid)
		else $error("loaded word not presented at the output");
`endif

endmodule

`default_nettype wire

FILE: design/efe_expand.sv
// efe_expand: running CRC register and the logic that turns one registered
// input word into its list of framed output words. Uses efe_pkg.
`default_nettype none

module efe_expand import efe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data,
	input  wire logic       first,
	input  wire logic       last,
	input  wire logic       take,
	output efe_frame_t      frame
);

	logic [7:0]       crc_q;
	logic [7:0]       crc_base;
	logic [7:0]       crc_1;
	logic [7:0]       crc_2;
	esc_t             esc_d;
	esc_t             esc_c;
	logic [CNT_W-1:0] n;

	assign esc_d    = escape(data);
	assign crc_base = first ? CRC_INIT : crc_q;
	assign crc_1    = crc_feed(crc_base, esc_d.b0);
	assign crc_2    = esc_d.two ? crc_feed(crc_1, esc_d.b1) : crc_1;
	assign esc_c    = escape(crc_2);

	always_comb begin
		frame.bytes  = '0;
		frame.closes = last;
		n            = '0;
		if (first) begin
			frame.bytes[n[IDX_W-1:0]] = HEAD_BYTE;
			n = n + 1'b1;
		end
		frame.bytes[n[IDX_W-1:0]] = esc_d.b0;
		n = n + 1'b1;
		if (esc_d.two) begin
			frame.bytes[n[IDX_W-1:0]] = esc_d.b1;
			n = n + 1'b1;
		end
		if (last) begin
			frame.bytes[n[IDX_W-1:0]] = esc_c.b0;
			n = n + 1'b1;
			if (esc_c.two) begin
				frame.bytes[n[IDX_W-1:0]] = esc_c.b1;
				n = n + 1'b1;
			end
			frame.bytes[n[IDX_W-1:0]] = TAIL_BYTE;
			n = n + 1'b1;
		end
		frame.cnt = n;
	end

	// CRC is not fed by its own escaped copy; tail restarts it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (take) begin
			crc_q <= last ? CRC_INIT : crc_2;
		end
	end

endmodule

`default_nettype wire

FILE: design/efe_out_buf.sv
// efe_out_buf: result register holding the words of one input word and
// sending them out one per cycle while out_ready is high. Uses efe_pkg.
`default_nettype none

module efe_out_buf import efe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire efe_frame_t frame,
	output logic            free,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            frame_end
);

	logic [MAX_BYTES-1:0][7:0] bytes_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          idx_q;
	logic                      closes_q;
	logic                      valid_q;
	logic                      at_end;

	assign at_end    = (idx_q + 1'b1) == cnt_q;
	assign free      = !valid_q || (out_ready && at_end);
	assign out_valid = valid_q;
	assign out_byte  = bytes_q[idx_q[IDX_W-1:0]];
	assign frame_end = closes_q && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= frame.bytes;
			cnt_q    <= frame.cnt;
			closes_q <= frame.closes;
		end
	end

endmodule

`default_nettype wire
